// ===== src/cpl_pkg.sv =====
package cpl_pkg;

  // list geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int OCNT_W   = 5;

  // command codes
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_INSERT_AT  = 3'd2,
    CMD_SEARCH     = 3'd3,
    CMD_DEL_VALUE  = 3'd4,
    CMD_DEL_AT     = 3'd5,
    CMD_CLEAR      = 3'd6,
    CMD_READ_AT    = 3'd7
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DEL,
    S_INS,
    S_RDW,
    S_FIN
  } state_t;

  // element store access, one write and one read port
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  // one result item
  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] data;
    logic [POS_W-1:0]  idx;
    logic [OCNT_W-1:0] cnt;
  } res_t;

  // failed operations report all-ones data and index zero
  function automatic res_t make_res(status_t st, logic [DATA_W-1:0] data,
                                    logic [POS_W-1:0] idx, logic [CNT_W-1:0] cnt);
    res_t r;
    r.status = st;
    r.data   = (st == ST_OK) ? data : '1;
    r.idx    = (st == ST_OK) ? idx : '0;
    r.cnt    = OCNT_W'(cnt);
    return r;
  endfunction

endpackage

// ===== src/circular_positional_list_core.sv =====
// sequence: clear and rejected items go straight from idle to the result; reads
//   wait on the registered store read, and search, insert and delete walk the list
// throughput: one item at a time; the walk is one entry per cycle through the
//   single read and single write port of the element store
// reset: synchronous, empties the list and drops any pending result item
module circular_positional_list_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // cmd[2:0], value[34:3], position[42:35], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // status[1:0], data_out[33:2], found_index[41:34],
                                 // entry_count[46:42], zero fill
);
  import cpl_pkg::*;

  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_ready;
  res_t              res;

  cpl_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  cpl_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_cmd      (cmd_t'(s_tdata[2:0])),
    .in_value    (s_tdata[34:3]),
    .in_position (s_tdata[42:35]),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {1'b0, res.cnt, res.idx, res.data, res.status};
    end
  end

endmodule

// ===== src/cpl_mem.sv =====
module cpl_mem (
  input  logic                                clk,
  input  cpl_pkg::mem_req_t                   req,
  output logic [cpl_pkg::DATA_W-1:0]          rdata
);
  import cpl_pkg::*;

  logic [DATA_W-1:0] mem [CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

// ===== src/cpl_ctrl.sv =====
module cpl_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cpl_pkg::cmd_t                 in_cmd,
  input  logic [cpl_pkg::DATA_W-1:0]    in_value,
  input  logic [cpl_pkg::POS_W-1:0]     in_position,
  output cpl_pkg::mem_req_t             mem_req,
  input  logic [cpl_pkg::DATA_W-1:0]    mem_rdata,
  output logic                          res_valid,
  input  logic                          res_ready,
  output cpl_pkg::res_t                 res
);
  import cpl_pkg::*;

  state_t             state, state_next;
  logic [CNT_W-1:0]   count;
  logic               go;
  logic               pend;
  logic [IDX_W-1:0]   rp;
  logic [IDX_W-1:0]   pa;
  logic [IDX_W-1:0]   pos;
  logic [DATA_W-1:0]  key;
  logic [DATA_W-1:0]  d;
  cmd_t               op;

  logic               accept;
  logic [POS_W-1:0]   ipos;
  logic               ins_bad;
  logic               full;
  logic               pos_bad;
  logic               match;
  logic [IDX_W-1:0]   last;
  logic               done_walk;

  assign accept    = in_valid && in_ready;
  assign full      = count >= CNT_W'(CAPACITY);
  assign ins_bad   = ipos > POS_W'(count);
  assign pos_bad   = in_position >= POS_W'(count);
  assign match     = pend && (mem_rdata == key);
  assign last      = IDX_W'(count - CNT_W'(1));
  assign done_walk = !go && !pend;

  // insert position per command
  always_comb begin
    case (in_cmd)
      CMD_PUSH_FRONT: ipos = '0;
      CMD_PUSH_BACK:  ipos = POS_W'(count);
      default:        ipos = in_position;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT:
              state_next = (ins_bad || full) ? S_FIN : S_INS;
            CMD_SEARCH, CMD_DEL_VALUE: state_next = S_SCAN;
            CMD_DEL_AT:   state_next = pos_bad ? S_FIN : S_DEL;
            CMD_READ_AT:  state_next = pos_bad ? S_FIN : S_RDW;
            default:      state_next = S_FIN;
          endcase
        end
      end
      S_SCAN: begin
        if (match) begin
          state_next = (op == CMD_DEL_VALUE) ? S_DEL : S_FIN;
        end else if (done_walk) begin
          state_next = S_FIN;
        end
      end
      S_DEL, S_INS: begin
        if (done_walk) begin
          state_next = S_FIN;
        end
      end
      S_RDW: state_next = S_FIN;
      S_FIN: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // handshake and store port
  always_comb begin
    in_ready      = (state == S_IDLE);
    res_valid     = (state == S_FIN);
    mem_req.we    = 1'b0;
    mem_req.waddr = pos;
    mem_req.wdata = mem_rdata;
    mem_req.raddr = rp;
    case (state)
      S_IDLE: mem_req.raddr = IDX_W'(in_position);
      S_DEL: begin
        // move each entry one place towards the head
        if (pend && (pa != pos)) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pa - IDX_W'(1);
        end
      end
      S_INS: begin
        // move each entry one place towards the tail, then drop in the new one
        if (pend) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pa + IDX_W'(1);
        end else if (!go) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos;
          mem_req.wdata = key;
        end
      end
      default: ;
    endcase
  end

  // state and list count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      go    <= 1'b0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          pend <= 1'b0;
          if (accept) begin
            case (in_cmd)
              CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT:
                go <= POS_W'(count) > ipos;
              CMD_SEARCH, CMD_DEL_VALUE: go <= (count != '0);
              CMD_DEL_AT: go <= 1'b1;
              CMD_CLEAR:  count <= '0;
              default:    go <= 1'b0;
            endcase
          end
        end
        S_SCAN: begin
          if (match) begin
            go   <= (op == CMD_DEL_VALUE);
            pend <= 1'b0;
          end else begin
            if (go && (rp == last)) go <= 1'b0;
            pend <= go;
          end
        end
        S_DEL: begin
          if (go && (rp == last)) go <= 1'b0;
          pend <= go;
          if (done_walk) count <= count - CNT_W'(1);
        end
        S_INS: begin
          if (go && (rp == pos)) go <= 1'b0;
          pend <= go;
          if (done_walk) count <= count + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // walk pointers, operands and result
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        key <= in_value;
        op  <= in_cmd;
        pos <= IDX_W'(in_position);
        case (in_cmd)
          CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
            pos <= IDX_W'(ipos);
            rp  <= last;
            if (ins_bad)   res <= make_res(ST_BADPOS, '0, '0, count);
            else if (full) res <= make_res(ST_FULL, '0, '0, count);
          end
          CMD_SEARCH, CMD_DEL_VALUE: rp <= '0;
          CMD_DEL_AT: begin
            rp <= IDX_W'(in_position);
            if (pos_bad) res <= make_res(ST_BADPOS, '0, '0, count);
          end
          CMD_CLEAR: res <= make_res(ST_OK, '0, '0, '0);
          default: begin
            if (pos_bad) res <= make_res(ST_BADPOS, '0, '0, count);
          end
        endcase
      end
      S_SCAN: begin
        if (go) rp <= rp + IDX_W'(1);
        pa <= rp;
        if (match) begin
          pos <= pa;
          rp  <= pa;
          res <= make_res(ST_OK, key, POS_W'(pa), count);
        end else if (done_walk) begin
          res <= make_res(ST_NOTFOUND, '0, '0, count);
        end
      end
      S_DEL: begin
        if (go) rp <= rp + IDX_W'(1);
        pa <= rp;
        if (pend && (pa == pos)) d <= mem_rdata;
        if (done_walk) res <= make_res(ST_OK, d, POS_W'(pos), count - CNT_W'(1));
      end
      S_INS: begin
        if (go) rp <= rp - IDX_W'(1);
        pa <= rp;
        if (done_walk) res <= make_res(ST_OK, key, POS_W'(pos), count + CNT_W'(1));
      end
      S_RDW: res <= make_res(ST_OK, mem_rdata, POS_W'(pos), count);
      default: ;
    endcase
  end

endmodule

// ===== src/cpl_checker.sv =====
module cpl_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);
  import cpl_pkg::*;

  // a result item waiting for the sink stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item dropped or changed while stalled");

  // an accepted item keeps the block from taking another item in the cycle after it
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again straight after an item");

  // failed operations carry all-ones data and index zero
  a_fail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != ST_OK) |-> (m_tdata[33:2] == '1) && (m_tdata[41:34] == '0))
    else $error("failed result item with data or index set");

  // the list never holds more than its capacity
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[46:42] <= OCNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // reset leaves no result item pending
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result item present after reset");

endmodule

bind circular_positional_list_core cpl_checker u_cpl_checker (.*);

// ===== sim/tb_circular_positional_list_core.sv =====
module tb_circular_positional_list_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cpl_pkg::*;

  localparam int RUN_LIMIT   = 200000;
  localparam int DRAIN_WAIT  = 48;
  localparam int HOLD_CYCLES = 250;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // cmd[2:0], value[34:3], position[42:35], zero fill
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // status[1:0], data_out[33:2], found_index[41:34],
                          // entry_count[46:42], zero fill

  // shadow copy of the list, head at entry 0
  logic [DATA_W-1:0] shadow_vals [CAPACITY];
  int                shadow_len = 0;

  res_t        awaited_replies [$];
  int unsigned fail_count     = 0;
  int unsigned reported       = 0;
  int unsigned cycle_count    = 0;
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_idle_pct    = 0;
  int unsigned hold_left      = 0;

  circular_positional_list_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
               awaited_replies.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // apply one command to the shadow list and work out its reply
  function automatic res_t apply_list_cmd(cmd_t c, logic [DATA_W-1:0] v,
                                          logic [POS_W-1:0] p);
    res_t              r;
    status_t           st;
    logic [DATA_W-1:0] d;
    int                at;
    st = ST_OK;
    d  = '0;
    at = 0;
    case (c)
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
        at = (c == CMD_PUSH_FRONT) ? 0 : (c == CMD_PUSH_BACK) ? shadow_len : int'(p);
        if (at > shadow_len) begin
          st = ST_BADPOS;
        end else if (shadow_len >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          for (int i = shadow_len; i > at; i--) shadow_vals[i] = shadow_vals[i-1];
          shadow_vals[at] = v;
          shadow_len++;
          d = v;
        end
      end
      CMD_SEARCH, CMD_DEL_VALUE: begin
        at = shadow_len;
        for (int i = shadow_len - 1; i >= 0; i--) if (shadow_vals[i] == v) at = i;
        if (at >= shadow_len) begin
          st = ST_NOTFOUND;
        end else begin
          d = shadow_vals[at];
          if (c == CMD_DEL_VALUE) begin
            for (int i = at; i + 1 < shadow_len; i++) shadow_vals[i] = shadow_vals[i+1];
            shadow_len--;
          end
        end
      end
      CMD_DEL_AT, CMD_READ_AT: begin
        at = int'(p);
        if (at >= shadow_len) begin
          st = ST_BADPOS;
        end else begin
          d = shadow_vals[at];
          if (c == CMD_DEL_AT) begin
            for (int i = at; i + 1 < shadow_len; i++) shadow_vals[i] = shadow_vals[i+1];
            shadow_len--;
          end
        end
      end
      default: begin
        // clear
        shadow_len = 0;
      end
    endcase
    r.status = st;
    r.data   = (st == ST_OK) ? d : '1;
    r.idx    = (st == ST_OK) ? POS_W'(at) : '0;
    r.cnt    = OCNT_W'(shadow_len);
    return r;
  endfunction

  // offer one item, wait for the handshake, then record its reply
  task automatic send_item(input cmd_t c, input logic [DATA_W-1:0] v,
                           input logic [POS_W-1:0] p);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, p, v, c};
    do @(posedge clk); while (!s_tready);
    awaited_replies.push_back(apply_list_cmd(c, v, p));
  endtask

  // receiver: random stalls, plus a long hold when one is requested
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // compare each reply with the oldest one awaited
  always @(posedge clk) begin
    res_t exp_r;
    res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status = status_t'(m_tdata[1:0]);
      got.data   = m_tdata[33:2];
      got.idx    = m_tdata[41:34];
      got.cnt    = m_tdata[46:42];
      if (awaited_replies.size() == 0) begin
        fail_count++;
        if (reported < 10) begin
          reported++;
          $display("%0t: reply with none awaited: st=%0d data=%h idx=%0d cnt=%0d",
                   $realtime, got.status, got.data, got.idx, got.cnt);
        end
      end else begin
        exp_r = awaited_replies.pop_front();
        if (got.status !== exp_r.status || got.data !== exp_r.data ||
            got.idx !== exp_r.idx || got.cnt !== exp_r.cnt) begin
          fail_count++;
          if (reported < 10) begin
            reported++;
            $display("%0t: mismatch exp st=%0d data=%h idx=%0d cnt=%0d",
                     $realtime, exp_r.status, exp_r.data, exp_r.idx, exp_r.cnt);
            $display("%0t:          got st=%0d data=%h idx=%0d cnt=%0d",
                     $realtime, got.status, got.data, got.idx, got.cnt);
          end
        end
      end
    end
  end

  // often small repeating values so that searches hit, plus extremes and noise
  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 4) return DATA_W'($signed($urandom_range(7)) - 4);
    if (sel == 4) begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom();
  endfunction

  // search key: usually an entry that is in the list
  function automatic logic [DATA_W-1:0] pick_key();
    if (shadow_len > 0 && $urandom_range(9) < 6)
      return shadow_vals[$urandom_range(shadow_len - 1)];
    return pick_value();
  endfunction

  // position: usually in range, sometimes anywhere in the field
  function automatic logic [POS_W-1:0] pick_pos(int top);
    if (top >= 0 && $urandom_range(4) != 0) return POS_W'($urandom_range(top));
    return POS_W'($urandom_range(255));
  endfunction

  // edges of every command on a short list
  task automatic test_directed();
    send_item(CMD_READ_AT,    32'd1, 8'd0);
    send_item(CMD_DEL_AT,     32'd2, 8'd0);
    send_item(CMD_SEARCH,     32'd5, 8'd0);
    send_item(CMD_DEL_VALUE,  32'd5, 8'd0);
    send_item(CMD_INSERT_AT,  32'd9, 8'd1);
    send_item(CMD_PUSH_FRONT, 32'h8000_0000, 8'hff);
    send_item(CMD_PUSH_BACK,  32'h7fff_ffff, 8'h00);
    send_item(CMD_INSERT_AT,  32'h0000_0000, 8'd0);
    send_item(CMD_INSERT_AT,  32'hffff_ffff, 8'd3);
    send_item(CMD_INSERT_AT,  32'd7, 8'd2);
    send_item(CMD_INSERT_AT,  32'd8, 8'd6);
    send_item(CMD_INSERT_AT,  32'd8, 8'd255);
    send_item(CMD_PUSH_BACK,  32'd7, 8'd0);
    send_item(CMD_SEARCH,     32'd7, 8'd0);
    send_item(CMD_SEARCH,     32'd12345, 8'd0);
    send_item(CMD_READ_AT,    32'd0, 8'd0);
    send_item(CMD_READ_AT,    32'd0, 8'd5);
    send_item(CMD_READ_AT,    32'd0, 8'd255);
    send_item(CMD_READ_AT,    32'd0, 8'd6);
    send_item(CMD_DEL_VALUE,  32'd7, 8'd0);
    send_item(CMD_DEL_AT,     32'd0, 8'd0);
    send_item(CMD_DEL_AT,     32'd0, 8'd3);
    send_item(CMD_DEL_AT,     32'd0, 8'd3);
    send_item(CMD_CLEAR,      32'hdead_beef, 8'haa);
    send_item(CMD_READ_AT,    32'd0, 8'd0);
  endtask

  // fill to capacity while the receiver holds off, then hit the full list
  task automatic test_fill_under_backpressure();
    send_item(CMD_CLEAR, pick_value(), pick_pos(-1));
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < CAPACITY; i++) begin
      if (i % 3 == 0) send_item(CMD_PUSH_FRONT, pick_value(), pick_pos(-1));
      else send_item(CMD_PUSH_BACK, pick_value(), pick_pos(-1));
    end
    send_item(CMD_PUSH_FRONT, pick_value(), 8'd0);
    send_item(CMD_PUSH_BACK,  pick_value(), 8'd0);
    send_item(CMD_INSERT_AT,  pick_value(), 8'(CAPACITY));
    send_item(CMD_INSERT_AT,  pick_value(), 8'(CAPACITY + 1));
    send_item(CMD_INSERT_AT,  pick_value(), 8'd0);
    send_item(CMD_READ_AT,    pick_value(), 8'(CAPACITY - 1));
    send_item(CMD_SEARCH,     shadow_vals[CAPACITY-1], 8'd0);
    send_item(CMD_DEL_VALUE,  shadow_vals[CAPACITY-1], 8'd0);
    send_item(CMD_DEL_AT,     pick_value(), 8'd0);
  endtask

  // random commands, drifting between growing and shrinking the list
  task automatic test_random(input int n_items);
    bit          growing;
    int unsigned sel;
    int unsigned ins_w;
    int unsigned del_w;
    cmd_t        c;
    logic [DATA_W-1:0] v;
    logic [POS_W-1:0]  p;
    growing = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) growing = ($urandom_range(2) != 0);
      ins_w = growing ? 55 : 20;
      del_w = growing ? 10 : 25;
      sel   = $urandom_range(99);
      if (sel < ins_w) begin
        case ($urandom_range(2))
          0: c = CMD_PUSH_FRONT;
          1: c = CMD_PUSH_BACK;
          default: c = CMD_INSERT_AT;
        endcase
      end else if (sel < ins_w + 10) c = CMD_SEARCH;
      else if (sel < ins_w + 10 + del_w) c = CMD_DEL_VALUE;
      else if (sel < ins_w + 10 + 2 * del_w) c = CMD_DEL_AT;
      else if (sel < 98) c = CMD_READ_AT;
      else c = CMD_CLEAR;
      case (c)
        CMD_SEARCH, CMD_DEL_VALUE: begin
          v = pick_key();
          p = pick_pos(-1);
        end
        CMD_INSERT_AT: begin
          v = pick_value();
          p = pick_pos(shadow_len);
        end
        CMD_DEL_AT, CMD_READ_AT: begin
          v = pick_value();
          p = pick_pos(shadow_len - 1);
        end
        default: begin
          v = pick_value();
          p = pick_pos(-1);
        end
      endcase
      send_item(c, v, p);
    end
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // sender mostly busy, receiver often stalled
    tx_idle_pct = 8;
    rx_idle_pct = 59;
    test_directed();
    test_random(190);

    // sender often idle, receiver mostly ready
    tx_idle_pct = 59;
    rx_idle_pct = 8;
    test_random(190);

    // no random idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_fill_under_backpressure();
    test_random(190);

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (awaited_replies.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0 && awaited_replies.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/cpl_pkg.sv
src/cpl_mem.sv
src/cpl_ctrl.sv
src/circular_positional_list_core.sv
src/cpl_checker.sv
sim/tb_circular_positional_list_core.sv
